### rtl/uwm_pkg.sv
// shared types, constants and the wide-range width lookup for the utf-8 width meter
`timescale 1ns / 1ps
`default_nettype none
package uwm_pkg;

	localparam logic [20:0] REPL_CP  = 21'h00FFFD;
	localparam logic [20:0] CP_MASK  = 21'h1FFFFF;
	localparam logic [7:0]  ASCII_LIM = 8'h80;
	localparam logic [7:0]  CONT_MASK = 8'hC0;
	localparam logic [7:0]  CONT_TAG  = 8'h80;
	localparam logic [7:0]  LEAD2_MASK = 8'hE0;
	localparam logic [7:0]  LEAD2_TAG  = 8'hC0;
	localparam logic [7:0]  LEAD3_MASK = 8'hF0;
	localparam logic [7:0]  LEAD3_TAG  = 8'hE0;
	localparam logic [7:0]  LEAD4_MASK = 8'hF8;
	localparam logic [7:0]  LEAD4_TAG  = 8'hF0;
	localparam logic [7:0]  PAY_MASK6  = 8'h3F;
	localparam logic [7:0]  PAY_MASK2  = 8'h1F;
	localparam logic [7:0]  PAY_MASK3  = 8'h0F;
	localparam logic [7:0]  PAY_MASK4  = 8'h07;
	localparam logic [20:0] CTRL_LIM   = 21'h000020;
	localparam logic [20:0] WIDE_START = 21'h001100;
	localparam logic [2:0]  LEN_NONE = 3'd0;
	localparam logic [2:0]  LEN_2    = 3'd2;
	localparam logic [2:0]  LEN_3    = 3'd3;
	localparam logic [2:0]  LEN_4    = 3'd4;
	localparam logic [1:0]  COLS_CTRL   = 2'd0;
	localparam logic [1:0]  COLS_NARROW = 2'd1;
	localparam logic [1:0]  COLS_WIDE   = 2'd2;
	localparam int          NUM_WIDE = 122;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_req_t;

	typedef struct packed {
		logic [20:0] cp_value;
		logic [1:0]  char_columns;
		logic        replaced;
		logic [31:0] running_columns;
		logic        last_of_run;
		logic        end_of_text;
	} char_res_t;

	// what one byte produces: rcnt lone replacements, then optionally one item
	typedef struct packed {
		logic [2:0]  rcnt;
		logic        has_item;
		logic [20:0] item_cp;
		logic [1:0]  item_cols;
		logic        item_rep;
		logic        last;
	} plan_t;

	localparam logic [20:0] WIDE_LO [NUM_WIDE] = '{
		21'h1100,21'h231A,21'h2329,21'h23E9,21'h23F0,21'h23F3,21'h25FD,21'h2614,
		21'h2630,21'h2648,21'h267F,21'h268A,21'h2693,21'h26A1,21'h26AA,21'h26BD,
		21'h26C4,21'h26CE,21'h26D4,21'h26EA,21'h26F2,21'h26F5,21'h26FA,21'h26FD,
		21'h2705,21'h270A,21'h2728,21'h274C,21'h274E,21'h2753,21'h2757,21'h2795,
		21'h27B0,21'h27BF,21'h2B1B,21'h2B50,21'h2B55,21'h2E80,21'h2E9B,21'h2F00,
		21'h2FF0,21'h3041,21'h3099,21'h3105,21'h3131,21'h3190,21'h31EF,21'h3220,
		21'h3250,21'hA490,21'hA960,21'hAC00,21'hF900,21'hFE10,21'hFE30,21'hFE54,
		21'hFE68,21'hFF01,21'hFFE0,21'h16FE0,21'h16FF0,21'h17000,21'h18800,21'h18CFF,
		21'h1AFF0,21'h1AFF5,21'h1AFFD,21'h1B000,21'h1B132,21'h1B150,21'h1B155,21'h1B164,
		21'h1B170,21'h1D300,21'h1D360,21'h1F004,21'h1F0CF,21'h1F18E,21'h1F191,21'h1F200,
		21'h1F210,21'h1F240,21'h1F250,21'h1F260,21'h1F300,21'h1F32D,21'h1F337,21'h1F37E,
		21'h1F3A0,21'h1F3CF,21'h1F3E0,21'h1F3F4,21'h1F3F8,21'h1F440,21'h1F442,21'h1F4FF,
		21'h1F54B,21'h1F550,21'h1F57A,21'h1F595,21'h1F5A4,21'h1F5FB,21'h1F680,21'h1F6CC,
		21'h1F6D0,21'h1F6D5,21'h1F6DC,21'h1F6EB,21'h1F6F4,21'h1F7E0,21'h1F7F0,21'h1F90C,
		21'h1F93C,21'h1F947,21'h1FA70,21'h1FA80,21'h1FA8F,21'h1FACE,21'h1FADF,21'h1FAF0,
		21'h20000,21'h30000};
	localparam logic [20:0] WIDE_HI [NUM_WIDE] = '{
		21'h115F,21'h231B,21'h232A,21'h23EC,21'h23F0,21'h23F3,21'h25FE,21'h2615,
		21'h2637,21'h2653,21'h267F,21'h268F,21'h2693,21'h26A1,21'h26AB,21'h26BE,
		21'h26C5,21'h26CE,21'h26D4,21'h26EA,21'h26F3,21'h26F5,21'h26FA,21'h26FD,
		21'h2705,21'h270B,21'h2728,21'h274C,21'h274E,21'h2755,21'h2757,21'h2797,
		21'h27B0,21'h27BF,21'h2B1C,21'h2B50,21'h2B55,21'h2E99,21'h2EF3,21'h2FD5,
		21'h303E,21'h3096,21'h30FF,21'h312F,21'h318E,21'h31E5,21'h321E,21'h3247,
		21'hA48C,21'hA4C6,21'hA97C,21'hD7A3,21'hFAFF,21'hFE19,21'hFE52,21'hFE66,
		21'hFE6B,21'hFF60,21'hFFE6,21'h16FE4,21'h16FF1,21'h187F7,21'h18CD5,21'h18D08,
		21'h1AFF3,21'h1AFFB,21'h1AFFE,21'h1B122,21'h1B132,21'h1B152,21'h1B155,21'h1B167,
		21'h1B2FB,21'h1D356,21'h1D376,21'h1F004,21'h1F0CF,21'h1F18E,21'h1F19A,21'h1F202,
		21'h1F23B,21'h1F248,21'h1F251,21'h1F265,21'h1F320,21'h1F335,21'h1F37C,21'h1F393,
		21'h1F3CA,21'h1F3D3,21'h1F3F0,21'h1F3F4,21'h1F43E,21'h1F440,21'h1F4FC,21'h1F53D,
		21'h1F54E,21'h1F567,21'h1F57A,21'h1F596,21'h1F5A4,21'h1F64F,21'h1F6C5,21'h1F6CC,
		21'h1F6D2,21'h1F6D7,21'h1F6DF,21'h1F6EC,21'h1F6FC,21'h1F7EB,21'h1F7F0,21'h1F93A,
		21'h1F945,21'h1F9FF,21'h1FA7C,21'h1FA89,21'h1FAC6,21'h1FADC,21'h1FAE9,21'h1FAF8,
		21'h2FFFD,21'h3FFFD};

	// parallel range compare over the whole table
	function automatic logic [1:0] columns_of(input logic [20:0] cp);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_WIDE; k++) begin
			hit = hit | ((cp >= WIDE_LO[k]) && (cp <= WIDE_HI[k]));
		end
		if (cp < CTRL_LIM) return COLS_CTRL;
		if (cp < WIDE_START) return COLS_NARROW;
		return hit ? COLS_WIDE : COLS_NARROW;
	endfunction

endpackage
`default_nettype wire

### rtl/uwm_decode.sv
// sequence decoder: holds the open utf-8 sequence and turns each byte into an emit plan
`timescale 1ns / 1ps
`default_nettype none
module uwm_decode import uwm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      take,
	input  wire byte_req_t req,
	output plan_t          plan
);

	logic [20:0] pv_q;
	logic [2:0]  nl_q;
	logic [1:0]  bh_q;
	logic [20:0] pv_n;
	logic [2:0]  nl_n;
	logic [1:0]  bh_n;
	logic [2:0]  rcnt;
	logic        has_item;
	logic [20:0] item_cp;
	logic        item_rep;
	logic        do_lead;
	logic [7:0]  b;

	always_comb begin
		b        = req.data_byte;
		pv_n     = pv_q;
		nl_n     = nl_q;
		bh_n     = bh_q;
		rcnt     = 3'd0;
		has_item = 1'b0;
		item_cp  = REPL_CP;
		item_rep = 1'b0;
		do_lead  = 1'b0;
		if (nl_q == LEN_NONE) begin
			do_lead = 1'b1;
		end else if ((b & CONT_MASK) == CONT_TAG) begin
			pv_n = ((pv_q << 6) | 21'(b & PAY_MASK6)) & CP_MASK;
			bh_n = bh_q + 2'd1;
			if ((3'(bh_n) + 3'd1) >= nl_q) begin
				has_item = 1'b1;
				item_cp  = pv_n;
				nl_n = LEN_NONE;
				bh_n = 2'd0;
				pv_n = '0;
			end
		end else begin
			// broken sequence: lead plus each held byte replaced
			rcnt    = 3'd1 + 3'(bh_q);
			nl_n    = LEN_NONE;
			bh_n    = 2'd0;
			pv_n    = '0;
			do_lead = 1'b1;
		end
		if (do_lead) begin
			if (b < ASCII_LIM) begin
				has_item = 1'b1;
				item_cp  = 21'(b);
			end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
				nl_n = LEN_2; bh_n = 2'd0; pv_n = 21'(b & PAY_MASK2);
			end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
				nl_n = LEN_3; bh_n = 2'd0; pv_n = 21'(b & PAY_MASK3);
			end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
				nl_n = LEN_4; bh_n = 2'd0; pv_n = 21'(b & PAY_MASK4);
			end else begin
				has_item = 1'b1;
				item_rep = 1'b1;
			end
		end
		// truncated at end of text
		if (req.last_byte && nl_n != LEN_NONE) begin
			rcnt = rcnt + 3'd1 + 3'(bh_n);
		end
		if (req.last_byte) begin
			nl_n = LEN_NONE;
			bh_n = 2'd0;
			pv_n = '0;
		end
		plan.rcnt      = rcnt;
		plan.has_item  = has_item;
		plan.item_cp   = item_cp;
		plan.item_cols = columns_of(item_cp);
		plan.item_rep  = item_rep;
		plan.last      = req.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
			nl_q <= LEN_NONE;
			bh_q <= 2'd0;
		end else if (take) begin
			pv_q <= pv_n;
			nl_q <= nl_n;
			bh_q <= bh_n;
		end
	end

endmodule
`default_nettype wire

### rtl/uwm_emit.sv
// plan register, result register and saturating column total
`timescale 1ns / 1ps
`default_nettype none
module uwm_emit import uwm_pkg::*; #(
	parameter int SUM_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	output logic           take,
	input  wire plan_t     plan,
	output logic           res_valid,
	input  wire logic      res_stall,
	output char_res_t      res
);

	plan_t               plan_s1;
	logic                plan_vld_s1;
	logic [SUM_BITS-1:0] sum_q;
	logic                out_free;
	logic                piece_final;
	logic                take_piece;
	logic                is_repl;
	logic [1:0]          cols;
	logic [SUM_BITS:0]   sum_wide;
	logic [SUM_BITS-1:0] sum_n;

	assign out_free    = !res_valid || !res_stall;
	assign is_repl     = plan_s1.rcnt != 3'd0;
	assign piece_final = (plan_s1.rcnt == 3'd0) || (plan_s1.rcnt == 3'd1 && !plan_s1.has_item);
	assign take_piece  = plan_vld_s1 && out_free;
	assign req_stall   = plan_vld_s1 && !(take_piece && piece_final);
	assign take        = req_valid && !req_stall;
	assign cols        = is_repl ? COLS_NARROW : plan_s1.item_cols;
	assign sum_wide    = {1'b0, sum_q} + (SUM_BITS + 1)'(cols);
	assign sum_n       = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_vld_s1 <= 1'b0;
			res_valid   <= 1'b0;
			sum_q       <= '0;
		end else begin
			if (take) begin
				plan_vld_s1 <= (plan.rcnt != 3'd0) || plan.has_item;
			end else if (take_piece && piece_final) begin
				plan_vld_s1 <= 1'b0;
			end
			if (take_piece) begin
				res_valid <= 1'b1;
				sum_q     <= (piece_final && plan_s1.last) ? '0 : sum_n;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			plan_s1 <= plan;
		end else if (take_piece && is_repl) begin
			plan_s1.rcnt <= plan_s1.rcnt - 3'd1;
		end
		if (take_piece) begin
			res.cp_value        <= is_repl ? REPL_CP : plan_s1.item_cp;
			res.char_columns    <= cols;
			res.replaced        <= is_repl ? 1'b1 : plan_s1.item_rep;
			res.running_columns <= 32'(sum_n);
			res.last_of_run     <= piece_final;
			res.end_of_text     <= piece_final && plan_s1.last;
		end
	end

endmodule
`default_nettype wire

### rtl/utf8_display_width_meter.sv
// top level of the utf-8 display width meter
//  channel | dir | payload    | handshake
//  byte    | in  | byte_req_t | byte_valid / byte_stall
//  char    | out | char_res_t | char_valid / char_stall
// a byte is decoded in the cycle it is taken; its results leave from the result register
// one result per cycle while not stalled; a byte's 1..4 results hold the byte channel
// a byte giving no result (open sequence) does not hold the byte channel
// reset clears the open sequence, the column total and both valid flags
// char_stall holds the result register and then the plan register in place
`timescale 1ns / 1ps
`default_nettype none
module utf8_display_width_meter import uwm_pkg::*; #(
	parameter int SUM_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	output logic           byte_stall,
	input  wire byte_req_t byte_req,
	output logic           char_valid,
	input  wire logic      char_stall,
	output char_res_t      char_res
);

	plan_t plan;
	logic  take;

	uwm_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (byte_req),
		.plan   (plan)
	);

	uwm_emit #(.SUM_BITS(SUM_BITS)) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (byte_valid),
		.req_stall (byte_stall),
		.take      (take),
		.plan      (plan),
		.res_valid (char_valid),
		.res_stall (char_stall),
		.res       (char_res)
	);

endmodule
`default_nettype wire

### rtl/uwm_checker.sv
// port-level checks for the utf-8 display width meter
`timescale 1ns / 1ps
`default_nettype none
module uwm_checker import uwm_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      char_valid,
	input wire logic      char_stall,
	input wire char_res_t char_res
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_res))
		else $error("result changed while stalled");

	a_eot: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_res.end_of_text |-> char_res.last_of_run)
		else $error("end of text without last of run");

	a_repl: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_res.replaced |->
			char_res.cp_value == REPL_CP && char_res.char_columns == COLS_NARROW)
		else $error("replacement with wrong value or width");

	a_cols: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> char_res.char_columns != 2'd3)
		else $error("illegal column count");

endmodule

bind utf8_display_width_meter uwm_checker u_uwm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.char_res   (char_res)
);
`default_nettype wire
